// ===== rtl/core/bsk_pkg.sv =====
package bsk_pkg;

  // Window depth in characters and number of keys that are compared
  localparam int unsigned KEY_CHARS = 8;
  localparam int unsigned NUM_KEYS  = 4;

  // Register file shape
  localparam int unsigned KEY_REGS     = 4;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned KEY_REG_CHAR = KEY_W / 8;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned LENS_W       = KEY_REGS * LEN_W;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned MASK_W       = 4;

  // First key index that counts as a stop key
  localparam int unsigned FIRST_STOP_KEY = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ZERO    = 3'd0,
    REG_KEY_ONE     = 3'd1,
    REG_KEY_TWO     = 3'd2,
    REG_KEY_THREE   = 3'd3,
    REG_KEY_LENGTHS = 3'd4,
    REG_TIMEOUT     = 3'd5
  } cfg_reg_e;

  // Byte handed from one window cell to the next
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } link_t;

  // Result item, last field in the lowest bit
  typedef struct packed {
    logic [MASK_W-1:0] matched_mask;
    logic              timed_out;
    logic              no_retry;
    logic              aborted;
    logic              finished;
  } result_t;

endpackage

// ===== rtl/core/bsk_cell.sv =====
// One position of the receive window: holds one byte and its valid bit,
// passes it on to the older neighbour on each shift, and extends the
// per-key match chain with the compare at this position.
module bsk_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  bsk_pkg::link_t                      link_i,
  output bsk_pkg::link_t                      link_o,
  input  logic [bsk_pkg::NUM_KEYS-1:0][7:0]   key_char_i,
  input  logic [bsk_pkg::NUM_KEYS-1:0]        active_i,
  input  logic [bsk_pkg::NUM_KEYS-1:0]        match_i,
  output logic [bsk_pkg::NUM_KEYS-1:0]        match_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  // Take the neighbour's byte on a shift, else hold
  assign valid_d = shift_i ? link_i.valid : valid_q;
  assign data_d  = shift_i ? link_i.data  : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.data  = data_q;

  // Compare against the byte this position will hold after the shift
  always_comb begin
    for (int k = 0; k < bsk_pkg::NUM_KEYS; k++) begin
      match_o[k] = match_i[k] &
                   (!active_i[k] | (valid_d & (data_d == key_char_i[k])));
    end
  end

endmodule

// ===== rtl/core/boot_stop_key_matcher.sv =====
// Channel   Dir  Payload                                      Handshake
// s_axis    in   tdata: rx_byte; tuser: kind (1 = tick)       tvalid/tready
// m_axis    out  tdata: finished, aborted, no_retry,          tvalid/tready
//                timed_out, matched_mask[3:0]
// cfg       in   cfg_idx_i selects register, cfg_data_i value  cfg_we_i, no wait
//
// For each item the window shifts, all key compares run along the cell
// chain and the result lands in the output register at the same edge. One
// item per cycle is sustained; the window chain of KEY_CHARS cells
// sets the compare depth. A held result stalls input only when the output
// register is full and m_axis_tready is low. Reset clears window, tick
// counter, flags and registers; no clearing pass is needed.
module boot_stop_key_matcher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  input  logic                              s_axis_tuser,  // [0] kind
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [0] finished, [1] aborted,
                                                           // [2] no_retry, [3] timed_out,
                                                           // [7:4] matched_mask
  // Register writes
  input  logic                              cfg_we_i,
  input  logic [bsk_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bsk_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned NK = bsk_pkg::NUM_KEYS;
  localparam int unsigned NC = bsk_pkg::KEY_CHARS;

  logic [bsk_pkg::KEY_REGS-1:0][bsk_pkg::KEY_W-1:0] key_q;
  logic [bsk_pkg::KEY_REGS-1:0][bsk_pkg::LEN_W-1:0] len_q;
  logic [bsk_pkg::TICK_W-1:0]                        timeout_q;

  logic [bsk_pkg::TICK_W-1:0] tick_q, tick_d, tick_inc;
  logic abort_q, abort_d, stop_q, stop_d, expired_q, expired_d;

  logic            out_valid_q;
  bsk_pkg::result_t out_q, out_d;

  logic accept, done, shift, tick;
  logic [NK-1:0] hit, stop_hit, live;

  bsk_pkg::link_t                    link [NC+1];
  logic [NK-1:0]                     chain [NC+1];

  // Register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      len_q     <= '0;
      timeout_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsk_pkg::REG_KEY_ZERO,
        bsk_pkg::REG_KEY_ONE,
        bsk_pkg::REG_KEY_TWO,
        bsk_pkg::REG_KEY_THREE:   key_q[cfg_idx_i[1:0]] <= cfg_data_i[bsk_pkg::KEY_W-1:0];
        bsk_pkg::REG_KEY_LENGTHS: len_q     <= cfg_data_i[bsk_pkg::LENS_W-1:0];
        bsk_pkg::REG_TIMEOUT:     timeout_q <= cfg_data_i[bsk_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept whenever the output register is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign done          = abort_q || expired_q;
  assign shift         = accept && !done && !s_axis_tuser;
  assign tick          = accept && !done &&  s_axis_tuser;

  // Newest byte enters the head of the chain; keys start live if non-empty
  assign link[0]  = {1'b1, s_axis_tdata};
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      live[k] = (len_q[k] != '0);
    end
  end
  assign chain[0] = live;

  // Window cells, newest byte in cell zero
  for (genvar j = 0; j < NC; j++) begin : g_cell
    logic [NK-1:0][7:0] kc;
    logic [NK-1:0]      act;
    for (genvar k = 0; k < NK; k++) begin : g_key
      if (j < bsk_pkg::KEY_REG_CHAR) begin : g_chr
        assign kc[k] = key_q[k][8*j +: 8];
      end else begin : g_zero
        assign kc[k] = '0;
      end
      assign act[k] = (32'(len_q[k]) > 32'(j));
    end
    bsk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .link_i     (link[j]),
      .link_o     (link[j+1]),
      .key_char_i (kc),
      .active_i   (act),
      .match_i    (chain[j]),
      .match_o    (chain[j+1])
    );
  end

  // Key hits only count on an accepted byte
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      hit[k]      = shift && chain[NC][k];
      stop_hit[k] = hit[k] && (k >= bsk_pkg::FIRST_STOP_KEY);
    end
  end

  // Saturating tick counter and session flags
  assign tick_inc  = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
  assign tick_d    = tick ? tick_inc : tick_q;
  assign expired_d = expired_q || (tick && (tick_inc > timeout_q));
  assign abort_d   = abort_q || (|hit);
  assign stop_d    = stop_q  || (|stop_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      abort_q   <= 1'b0;
      stop_q    <= 1'b0;
      expired_q <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      abort_q   <= abort_d;
      stop_q    <= stop_d;
      expired_q <= expired_d;
    end
  end

  // Build the result item
  always_comb begin
    out_d              = '0;
    out_d.finished     = abort_d || expired_d;
    out_d.aborted      = abort_d;
    out_d.no_retry     = stop_d;
    out_d.timed_out    = expired_d && !abort_d;
    out_d.matched_mask = bsk_pkg::MASK_W'(hit);
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== bench/tb_boot_stop_key_matcher.sv =====
`timescale 1ns / 1ps

module tb_boot_stop_key_matcher;
  import bsk_pkg::*;

  localparam bit KIND_BYTE = 1'b0;
  localparam bit KIND_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 228;
  localparam int unsigned WIN_W        = KEY_CHARS * 8;
  // Opening bytes, first sent in the low byte: 5A first, then both extremes
  localparam logic [63:0] OPENING_BYTES = 64'hFFFE_017F_8000_FF5A;

  typedef enum int {
    END_TIMEOUT,
    END_DELAY_KEY,
    END_STOP_KEY
  } ending_e;

  // Predicted session state and the queue of status items still due
  class session_status_board;
    logic [KEY_W-1:0]  keys [KEY_REGS];
    logic [LENS_W-1:0] lens;
    logic [TICK_W-1:0] limit;
    logic [WIN_W-1:0]  window;
    int unsigned       fill;
    logic [TICK_W-1:0] ticks;
    bit                abort_seen;
    bit                stop_seen;
    bit                expired;
    result_t           status_due[$];
    int unsigned       mismatches;

    function new();
      foreach (keys[k]) keys[k] = '0;
      lens       = '0;
      limit      = '0;
      window     = '0;
      fill       = 0;
      ticks      = '0;
      abort_seen = 1'b0;
      stop_seen  = 1'b0;
      expired    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KEY_ZERO, REG_KEY_ONE, REG_KEY_TWO, REG_KEY_THREE:
          keys[idx] = val[KEY_W-1:0];
        REG_KEY_LENGTHS: lens = val[LENS_W-1:0];
        REG_TIMEOUT: limit = val[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // Key length with overlong values clamped to the window depth
    function int unsigned key_len(int k);
      int unsigned n;
      n = 32'(lens[LEN_W*k +: LEN_W]);
      if (n > KEY_CHARS) n = KEY_CHARS;
      return n;
    endfunction

    // Work out the status after one item; keep the new state only on commit
    function result_t next_status(bit kind, logic [7:0] rx, bit commit);
      logic [WIN_W-1:0]  win_n;
      logic [WIN_W-1:0]  key_x;
      logic [WIN_W-1:0]  span;
      int unsigned       fill_n;
      int unsigned       n;
      logic [TICK_W-1:0] ticks_n;
      bit                abort_n;
      bit                stop_n;
      bit                exp_n;
      logic [MASK_W-1:0] mask;
      result_t           st;
      win_n   = window;
      fill_n  = fill;
      ticks_n = ticks;
      abort_n = abort_seen;
      stop_n  = stop_seen;
      exp_n   = expired;
      mask    = '0;
      if (!abort_seen && !expired) begin
        if (kind == KIND_BYTE) begin
          win_n = {window[WIN_W-9:0], rx};
          if (fill_n < KEY_CHARS) fill_n++;
          for (int k = 0; k < NUM_KEYS; k++) begin
            n     = key_len(k);
            key_x = keys[k];  // characters past the register compare against zero
            span  = '0;
            for (int j = 0; j < n; j++) span[8*j +: 8] = 8'hFF;
            if (n != 0 && fill_n >= n && ((win_n ^ key_x) & span) == '0) begin
              mask[k] = 1'b1;
              abort_n = 1'b1;
              if (k >= FIRST_STOP_KEY) stop_n = 1'b1;
            end
          end
        end else begin
          if (ticks_n != '1) ticks_n++;
          if (ticks_n > limit) exp_n = 1'b1;
        end
      end
      if (commit) begin
        window     = win_n;
        fill       = fill_n;
        ticks      = ticks_n;
        abort_seen = abort_n;
        stop_seen  = stop_n;
        expired    = exp_n;
      end
      st.finished     = abort_n || exp_n;
      st.aborted      = abort_n;
      st.no_retry     = stop_n;
      st.timed_out    = exp_n && !abort_n;
      st.matched_mask = mask;
      return st;
    endfunction

    function void note_item(bit kind, logic [7:0] rx);
      status_due.push_back(next_status(kind, rx, 1'b1));
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t %s: expected fin=%b abt=%b nrt=%b tmo=%b mask=%b, ",
                  "got fin=%b abt=%b nrt=%b tmo=%b mask=%b"},
                 $time, what, want.finished, want.aborted, want.no_retry, want.timed_out,
                 want.matched_mask, got.finished, got.aborted, got.no_retry, got.timed_out,
                 got.matched_mask);
    endfunction

    function void check_status(logic [7:0] bits);
      result_t got;
      result_t want;
      got = result_t'(bits);
      if (status_due.size() == 0) begin
        report("status item with no input outstanding", '0, got);
        return;
      end
      want = status_due.pop_front();
      if (got.finished !== want.finished || got.aborted !== want.aborted ||
          got.no_retry !== want.no_retry || got.timed_out !== want.timed_out ||
          got.matched_mask !== want.matched_mask)
        report("status mismatch", want, got);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  session_status_board sb;
  int unsigned         tx_idle_pct = 34;
  int unsigned         rx_idle_pct = 64;
  int unsigned         items_sent  = 0;
  int unsigned         cycle_count = 0;

  boot_stop_key_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the status side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Sample status items half a cycle ahead of the edge that takes them
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("boot_stop_key_matcher regression: fail");
    $finish;
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send(bit kind, logic [7:0] rx);
    bit took;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= rx;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    sb.note_item(kind, rx);
    items_sent++;
  endtask

  // Swap any item that would close the session for a harmless byte
  task automatic send_live(bit kind, logic [7:0] rx);
    result_t st;
    st = sb.next_status(kind, rx, 1'b0);
    while (st.finished && !(sb.abort_seen || sb.expired)) begin
      kind = KIND_BYTE;
      rx   = 8'($urandom);
      st   = sb.next_status(kind, rx, 1'b0);
    end
    send(kind, rx);
  endtask

  // Type a key oldest character first, with the odd tick in between
  task automatic play_key(int k);
    int unsigned n;
    n = sb.key_len(k);
    for (int j = int'(n) - 1; j >= 0; j--) begin
      if ($urandom_range(0, 9) == 0) send_live(KIND_TICK, 8'($urandom));
      send_live(KIND_BYTE, sb.keys[k][8*j +: 8]);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Write every register, then both spare indexes, which must be ignored
  task automatic load_config(logic [KEY_W-1:0] k0, logic [KEY_W-1:0] k1,
                             logic [KEY_W-1:0] k2, logic [KEY_W-1:0] k3,
                             logic [LENS_W-1:0] lens, logic [TICK_W-1:0] tmo);
    write_reg(REG_KEY_ZERO, k0);
    write_reg(REG_KEY_ONE, k1);
    write_reg(REG_KEY_TWO, k2);
    write_reg(REG_KEY_THREE, k3);
    write_reg(REG_KEY_LENGTHS, CFG_DATA_W'(lens));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(REG_SPARE_SIX, {$urandom, $urandom});
    write_reg(REG_SPARE_SEVEN, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return LEN_W'($urandom_range(KEY_CHARS + 1, 15));
      default: return LEN_W'($urandom_range(1, KEY_CHARS));
    endcase
  endfunction

  // Mostly near-miss key sequences, the rest loose bytes and ticks
  task automatic run_phase(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    int unsigned start;
    int unsigned r;
    bit          paused;
    wait_drained();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    load_config(rand_key(), rand_key(), rand_key(), rand_key(),
                {rand_len(), rand_len(), rand_len(), rand_len()},
                ($urandom_range(0, 3) == 0) ? '1 : TICK_W'(sb.ticks + $urandom_range(20, 400)));
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < count) begin
      // hold the sender once until every status item is back
      if (!paused && items_sent - start >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) play_key($urandom_range(0, NUM_KEYS - 1));
      else if (r < 85) send_live(KIND_BYTE, 8'($urandom));
      else send_live(KIND_TICK, 8'($urandom));
    end
  endtask

  initial begin
    logic [KEY_W-1:0] tail;
    ending_e          ending;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Eight-character key whose last character arrives first: too few bytes yet.
    // Zero timeout while only bytes flow; keys one to three left empty.
    load_config(64'h5A, '1, '0, {$urandom, $urandom}, 16'h0008, '0);
    for (int i = 0; i < 8; i++) send(KIND_BYTE, OPENING_BYTES[8*i +: 8]);

    // Overlong lengths on every key, endless timeout, ticks then a near miss
    wait_drained();
    load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, 16'hFFFF, '1);
    repeat (3) send(KIND_TICK, 8'($urandom));
    play_key(REG_KEY_TWO);

    run_phase(RANDOM_ITEMS, 34, 64);
    run_phase(RANDOM_ITEMS, 64, 34);
    run_phase(RANDOM_ITEMS, 0, 0);

    // Close the session one way or another, then show that nothing moves
    wait_drained();
    ending = ending_e'($urandom_range(0, 2));
    tail   = {$urandom, $urandom};
    case (ending)
      END_TIMEOUT: begin
        // limit one tick ahead: the second tick runs past it
        load_config(sb.keys[0], sb.keys[1], sb.keys[2], sb.keys[3], sb.lens,
                    TICK_W'(sb.ticks + 1));
        repeat (3) send(KIND_TICK, 8'($urandom));
      end
      END_DELAY_KEY: begin
        load_config(tail, tail, {$urandom, $urandom}, tail ^ 64'h1,
                    {4'd1, 4'd5, 4'd8, 4'd3}, '1);
        for (int j = KEY_CHARS - 1; j >= 0; j--) send(KIND_BYTE, tail[8*j +: 8]);
      end
      default: begin
        // one delay key and two stop keys hit on the same byte
        load_config({$urandom, $urandom}, tail, tail, tail,
                    {4'd6, 4'd15, 4'd2, 4'd4}, '1);
        for (int j = KEY_CHARS - 1; j >= 0; j--) send(KIND_BYTE, tail[8*j +: 8]);
      end
    endcase
    for (int i = 0; i < 16; i++) send(1'($urandom_range(0, 1)), 8'($urandom));
    for (int j = KEY_CHARS - 1; j >= 0; j--) send(KIND_BYTE, tail[8*j +: 8]);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("boot_stop_key_matcher regression: pass");
    end else begin
      $display("boot_stop_key_matcher regression: fail");
    end
    $finish;
  end

endmodule
